[hdl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pcr_pkg.sv]
package pcr_pkg;

  localparam int MAX_SOURCE_CHANNELS = 8;
  localparam int MAX_SINK_CHANNELS   = 8;

  localparam int CNT_W     = 4;
  localparam int CMP_W     = CNT_W + 1;
  localparam int SRC_IDX_W = (MAX_SOURCE_CHANNELS > 1) ? $clog2(MAX_SOURCE_CHANNELS) : 1;
  localparam int STORE_AW  = SRC_IDX_W + 1;
  localparam int STORE_DEPTH = 2 * (1 << SRC_IDX_W);

  localparam logic [3:0] MUTE_NIBBLE = 4'hf;

  typedef enum logic [2:0] {
    REG_SOURCE_CHANNELS = 3'd0,
    REG_SINK_CHANNELS   = 3'd1,
    REG_CHANNEL_MAP     = 3'd2,
    REG_SOURCE_WIDE     = 3'd3,
    REG_SINK_WIDE       = 3'd4,
    REG_SHIFT_AMOUNT    = 3'd5,
    REG_SHIFT_RIGHT     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  source_channels;
    logic [3:0]  dest_channels;
    logic [31:0] channel_map;
    logic        source_wide;
    logic        sink_wide;
    logic [4:0]  shift_amount;
    logic        shift_right;
  } cfg_t;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [SRC_IDX_W-1:0] addr;
    logic [31:0]          data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } job_evt_t;

  function automatic logic [31:0] sext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
                                                   input logic [CNT_W-1:0] maxn);
    if (n == '0) return CNT_W'(1);
    return (n > maxn) ? maxn : n;
  endfunction

endpackage

[hdl/pcr_frame_store.sv]
module pcr_frame_store (
  input  logic                     clk,
  input  pcr_pkg::store_wr_t       wr,
  input  logic [pcr_pkg::STORE_AW-1:0] rd_addr,
  output logic [31:0]              rd_data
);
  import pcr_pkg::*;

  // Two banks: one fills while the other drains.
  logic [31:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.addr}] <= wr.data;
    end
  end

  assign rd_data = mem[rd_addr];
endmodule

[hdl/pcr_job_queue.sv]
module pcr_job_queue (
  input  logic              clk,
  input  logic              rst,
  input  pcr_pkg::job_evt_t push,
  input  logic              pop,
  output logic              job_valid,
  output logic              job_bank
);
  import pcr_pkg::*;

  logic       bank_q [2];
  logic       head;
  logic       tail;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push.valid) begin
        bank_q[tail] <= push.bank;
        tail         <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign job_valid = (count != 2'd0);
  assign job_bank  = bank_q[head];
endmodule

[hdl/pcr_front.sv]
module pcr_front (
  input  logic               clk,
  input  logic               rst,
  input  pcr_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample,
  input  pcr_pkg::job_evt_t  pop,
  output pcr_pkg::store_wr_t wr,
  output pcr_pkg::job_evt_t  push
);
  import pcr_pkg::*;

  logic [SRC_IDX_W-1:0] pos;
  logic                 wbank;
  logic [1:0]           busy;
  logic [1:0]           busy_next;
  logic [SRC_IDX_W:0]   pos_inc;
  logic [CNT_W-1:0]     nsrc;
  logic                 accept;
  logic                 close;

  always_comb begin
    nsrc    = clamp_count(cfg.source_channels, CNT_W'(MAX_SOURCE_CHANNELS));
    pos_inc = {1'b0, pos} + (SRC_IDX_W+1)'(1);
    close   = CMP_W'(pos_inc) >= CMP_W'(nsrc);
    // Hold off while the fill bank still belongs to a pending frame.
    in_ready = !busy[wbank];
    accept   = in_valid && in_ready;

    wr.en   = accept;
    wr.bank = wbank;
    wr.addr = pos;
    wr.data = cfg.source_wide ? in_sample : sext16(in_sample);

    push.valid = accept && close;
    push.bank  = wbank;

    busy_next = busy;
    if (push.valid) busy_next[wbank] = 1'b1;
    if (pop.valid)  busy_next[pop.bank] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      wbank <= 1'b0;
      busy  <= 2'b00;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (close) begin
          pos   <= '0;
          wbank <= ~wbank;
        end else begin
          pos <= pos_inc[SRC_IDX_W-1:0];
        end
      end
    end
  end
endmodule

[hdl/pcr_back.sv]
module pcr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  pcr_pkg::cfg_t                cfg,
  input  logic                         job_valid,
  input  logic                         job_bank,
  output logic [pcr_pkg::STORE_AW-1:0] rd_addr,
  input  logic [31:0]                  rd_data,
  output pcr_pkg::job_evt_t            pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_sample,
  output logic [2:0]                   out_channel,
  output logic                         frame_last
);
  import pcr_pkg::*;

  logic [2:0]       k;
  logic [CNT_W-1:0] nsink;
  logic [CNT_W-1:0] nsrc;
  logic [3:0]       nib;
  logic             live;
  logic             last;
  logic             load;
  logic [31:0]      shifted;
  logic [31:0]      value;

  always_comb begin
    nsink   = clamp_count(cfg.dest_channels, CNT_W'(MAX_SINK_CHANNELS));
    nsrc    = clamp_count(cfg.source_channels, CNT_W'(MAX_SOURCE_CHANNELS));
    last    = (CNT_W'(k) + CNT_W'(1)) == nsink;
    nib     = cfg.channel_map[{k, 2'b00} +: 4];
    live    = (nib != MUTE_NIBBLE) && (nib < nsrc);
    rd_addr = {job_bank, nib[SRC_IDX_W-1:0]};
    shifted = cfg.shift_right ? 32'($signed(rd_data) >>> cfg.shift_amount)
                              : (rd_data << cfg.shift_amount);
    value   = live ? (cfg.sink_wide ? shifted : sext16(shifted)) : 32'd0;
    load    = job_valid && (!out_valid || out_ready);
    pop.valid = load && last;
    pop.bank  = job_bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      k         <= last ? 3'd0 : k + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sample  <= value;
      out_channel <= k;
      frame_last  <= last;
    end
  end
endmodule

[hdl/pcm_channel_remap_convert.sv]
// PCM channel remap and format converter.
// Input channel (in_valid/in_ready/in_sample): interleaved source samples,
// one word per handshake; source_channels words make one source frame.
// Output channel (out_valid/out_ready): one word per sink channel, carrying
// out_sample, out_channel and frame_last on the last sink channel.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no frame is in flight. Unknown indexes are dropped.
// The first result of a frame passes the job queue and the output register
// after the word that closes the frame is accepted. The input takes one word
// per cycle while in_ready is high; the output gives one word per cycle while
// a frame is queued and out_ready is high, via the single store read port.
// The frame store has two banks: the next frame fills one bank while the
// back end drains the other, so input stalls only when both are pending.
// When the receiver stalls, the output word holds, the back end halts, and
// input continues until both banks are full.
// Reset (rst, synchronous) restores register defaults, empties the job
// queue and restarts frame collection; store contents are left as they are.
module pcm_channel_remap_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sample,
  output logic [2:0]         out_channel,
  output logic               frame_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pcr_pkg::*;

  cfg_t                cfg;
  store_wr_t           wr;
  job_evt_t            push;
  job_evt_t            pop;
  logic                job_valid;
  logic                job_bank;
  logic [STORE_AW-1:0] rd_addr;
  logic [31:0]         rd_data;

  assign cfg_ready = 1'b1;

  // Register file: decode index, keep only the register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_channels <= 4'd2;
      cfg.dest_channels   <= 4'd2;
      cfg.channel_map     <= 32'h7654_3210;
      cfg.source_wide     <= 1'b0;
      cfg.sink_wide       <= 1'b0;
      cfg.shift_amount    <= 5'd0;
      cfg.shift_right     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_CHANNELS: cfg.source_channels <= cfg_data[3:0];
        REG_SINK_CHANNELS:   cfg.dest_channels   <= cfg_data[3:0];
        REG_CHANNEL_MAP:     cfg.channel_map     <= cfg_data;
        REG_SOURCE_WIDE:     cfg.source_wide     <= cfg_data[0];
        REG_SINK_WIDE:       cfg.sink_wide       <= cfg_data[0];
        REG_SHIFT_AMOUNT:    cfg.shift_amount    <= cfg_data[4:0];
        REG_SHIFT_RIGHT:     cfg.shift_right     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: collect samples, close frames, hand banks to the queue.
  pcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .pop       (pop),
    .wr        (wr),
    .push      (push)
  );

  pcr_frame_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Queue of closed frames, one bank id per entry.
  pcr_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop.valid),
    .job_valid (job_valid),
    .job_bank  (job_bank)
  );

  // Back: one sink channel per cycle into the output register while a job is queued and the output is not stalled.
  pcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job_valid   (job_valid),
    .job_bank    (job_bank),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .out_channel (out_channel),
    .frame_last  (frame_last)
  );
endmodule

[hdl/pcr_checker.sv]
`include "assert_macros.svh"

module pcr_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_sample,
  input logic [2:0]         out_channel,
  input logic               frame_last
);
  import pcr_pkg::*;

  logic [2:0] exp_ch;

  // Track the sink channel the next output word must carry.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_ch <= 3'd0;
    end else if (out_valid && out_ready) begin
      exp_ch <= frame_last ? 3'd0 : exp_ch + 3'd1;
    end
  end

  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_channel) && $stable(frame_last), "output word changed while stalled")
  `ASSERT_CLK_RST(a_channel_seq, clk, rst, out_valid |-> out_channel == exp_ch, "sink channel out of sequence")
  `ASSERT_CLK_RST(a_last_at_max, clk, rst, out_valid && out_channel == 3'(MAX_SINK_CHANNELS - 1) |-> frame_last, "frame not closed at last sink channel")
  `ASSERT_CLK(a_reset_idle, clk, rst |=> !out_valid, "output valid right after reset")
endmodule

bind pcm_channel_remap_convert pcr_checker u_checker (.*);
